/* design/selective_repeat_sender_top_macros.svh */
// ---------------------------------------------------------------------------
// selective repeat sender assertion macros
// concurrent check helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_TOP_MACROS_SVH
`ifndef SYNTH
`define SRS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srs same-cycle check failed");
`define SRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srs next-cycle check failed");
`else
`define SRS_ASSERT_NOW(lbl, ante, cons)
`define SRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/srs_pkg.sv */
// ---------------------------------------------------------------------------
// srs_pkg
// shared types, codes, checksum and window helpers of the selective repeat sender
// ---------------------------------------------------------------------------
`default_nettype none
package srs_pkg;
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_ACK     = 2'd1;
	localparam logic [1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [1:0] EV_NEW  = 2'd0;
	localparam logic [1:0] EV_RETX = 2'd1;
	localparam logic [1:0] EV_DONE = 2'd2;
	localparam logic [1:0] EV_FAIL = 2'd3;

	localparam logic [1:0] CFG_WINDOW  = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_RETRIES = 2'd2;

	localparam logic [7:0] DATA_FLAG = 8'h08;
	localparam int         ACK_BIT   = 1;
	localparam logic [4:0] WIN_MAX   = 5'd16;

	typedef struct packed {
		logic        acked;
		logic [3:0]  retry;
		logic [15:0] stamp;
	} ent_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  seq;
		logic [7:0]  flags;
		logic        len;
		logic [7:0]  data;
		logic [15:0] sum;
	} result_t;

	typedef struct packed {
		logic prod;
		logic fin;
	} push_t;

	// five bytes never exceed 16 bits, so no fold is needed
	function automatic logic [15:0] pkt_sum(input logic [7:0] s, input logic [7:0] a,
		input logic [7:0] f, input logic [7:0] l, input logic [7:0] d);
		logic [15:0] t;
		t = 16'(s) + 16'(a) + 16'(f) + 16'(l) + 16'(d);
		return ~t;
	endfunction

	function automatic logic [4:0] eff_win(input logic [4:0] w);
		logic [4:0] r;
		r = w;
		if (w == 5'd0) r = 5'd1;
		else if (w > WIN_MAX) r = WIN_MAX;
		return r;
	endfunction
endpackage
`default_nettype wire

/* design/srs_ram.sv */
// ---------------------------------------------------------------------------
// srs_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module srs_ram #(
	parameter int W = 8,
	parameter int D = 128,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/srs_outq.sv */
// ---------------------------------------------------------------------------
// srs_outq
// one pending result plus the output register; last is set on the pending
// result once the sequencer says the item is finished
// ---------------------------------------------------------------------------
`default_nettype none
module srs_outq
	import srs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire push_t   ctl,
	input  wire result_t beat,
	output logic         pend_v,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output logic [47:0]  m_tdata,  // tx_seq, tx_flags, tx_len, tx_data, tx_checksum, pad
	output logic [1:0]   m_tuser,  // event_kind
	output logic         m_tlast   // last_result
);
	result_t pend_q, out_q;
	logic    pend_v_q, out_v_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (ctl.prod) begin
				if (pend_v_q) out_v_q <= 1'b1;
				pend_v_q <= 1'b1;
			end else if (ctl.fin && pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.prod) begin
			pend_q <= beat;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (ctl.fin && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign pend_v   = pend_v_q;
	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_q.sum, out_q.data, out_q.len, out_q.flags, out_q.seq};
endmodule
`default_nettype wire

/* design/selective_repeat_sender_top.sv */
// ---------------------------------------------------------------------------
// selective_repeat_sender_top
// selective repeat arq sender, one message byte per data packet
// ---------------------------------------------------------------------------
// Items are taken one at a time: s_tready is high only while the sequencer is
// idle. A load that is not the final byte, and any beat that is ignored or
// rejected, stays in the idle state. The final load sends packets through
// ST_RF_CHK and ST_RF_EMIT. An accepted ack marks its entry in ST_ACK_WR,
// slides the base through ST_SCAN_RD and ST_SCAN_CHK, then refills the
// window or ends the transfer. A timeout scans the in-window entries via
// ST_TO_RD and ST_TO_CHK. The entry-state and message rams have registered
// read data, read once per entry step. Steps wait on a full output stage.
// No clearing pass: entry state is written fresh when a packet is first sent,
// and no entry at or past next_index is ever read.
`default_nettype none
`include "selective_repeat_sender_top_macros.svh"
module selective_repeat_sender_top
	import srs_pkg::*;
#(
	parameter int MAX_BYTES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input beats
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // data_byte, rx_seq, rx_ack_num, rx_flags, rx_len,
	                                   // rx_data, rx_checksum, now_ms
	input  wire logic [1:0]  s_tuser,  // command
	input  wire logic        s_tlast,  // last_byte
	// result beats
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // tx_seq, tx_flags, tx_len, tx_data, tx_checksum, pad
	output logic [1:0]       m_tuser,  // event_kind
	output logic             m_tlast,  // last_result
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int CW = $clog2(MAX_BYTES + 1);         // counts up to MAX_BYTES
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int SW = CW + 6;                        // base plus window
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BYTES);

	typedef enum logic [1:0] {PH_LOADING, PH_SENDING, PH_DONE, PH_FAILED} phase_t;
	typedef enum logic [3:0] {
		ST_IDLE, ST_RF_CHK, ST_RF_EMIT, ST_ACK_WR, ST_SCAN_RD, ST_SCAN_CHK,
		ST_SCAN_END, ST_TO_RD, ST_TO_CHK, ST_FIN
	} state_t;

	// configuration
	logic [4:0]  win_q;
	logic [15:0] tmo_q;
	logic [3:0]  retries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= 5'd4;
			tmo_q     <= 16'd350;
			retries_q <= 4'd15;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW:  win_q     <= cfg_data[4:0];
				CFG_TIMEOUT: tmo_q     <= cfg_data;
				CFG_RETRIES: retries_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [7:0]  in_byte, in_seq, in_ack, in_flags, in_len, in_data;
	logic [15:0] in_sum, in_now;
	assign in_byte  = s_tdata[7:0];
	assign in_seq   = s_tdata[15:8];
	assign in_ack   = s_tdata[23:16];
	assign in_flags = s_tdata[31:24];
	assign in_len   = s_tdata[39:32];
	assign in_data  = s_tdata[47:40];
	assign in_sum   = s_tdata[63:48];
	assign in_now   = s_tdata[79:64];

	state_t        state_q;
	phase_t        phase_q;
	logic [CW-1:0] len_q, base_q, next_q, idx_q;
	logic [15:0]   now_q;

	logic in_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// load: a finished transfer restarts the message with this byte
	logic          load_ok;
	logic [CW-1:0] len_eff;
	assign load_ok = (phase_q != PH_SENDING);
	assign len_eff = (phase_q == PH_LOADING) ? len_q : '0;

	// ack qualification: checksum, ack flag, sent and still in window
	logic [7:0] ack_idx;
	logic       ack_ok;
	assign ack_idx = in_ack - 8'd1;
	assign ack_ok  = (phase_q == PH_SENDING)
		&& (in_sum == pkt_sum(in_seq, in_ack, in_flags, in_len, in_data))
		&& in_flags[ACK_BIT]
		&& (in_ack != 8'd0) && (in_ack <= 8'(len_q))
		&& (ack_idx >= 8'(base_q)) && (ack_idx < 8'(next_q));

	// window room for a new packet
	logic win_room;
	assign win_room = (next_q < len_q) && (SW'(next_q) < SW'(base_q) + SW'(eff_win(win_q)));

	// memories
	logic          msg_we, ent_we;
	logic [AW-1:0] msg_waddr, msg_raddr, ent_waddr, ent_raddr;
	logic [7:0]    msg_rdata;
	ent_t          ent_wdata, ent_rdata;

	srs_ram #(.W(8), .D(MAX_BYTES)) u_msg_ram (
		.clk   (clk),
		.we    (msg_we),
		.waddr (msg_waddr),
		.wdata (in_byte),
		.raddr (msg_raddr),
		.rdata (msg_rdata)
	);

	srs_ram #(.W($bits(ent_t)), .D(MAX_BYTES)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	// result path
	push_t   push;
	result_t beat;
	logic    pend_v, out_free;
	assign out_free = !m_tvalid || m_tready;

	srs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (push),
		.beat     (beat),
		.pend_v   (pend_v),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// retransmit decision for the entry read in the previous cycle
	logic [15:0] age;
	logic        expired, exhausted;
	logic [7:0]  idx_seq, next_seq;
	assign age       = now_q - ent_rdata.stamp;
	assign expired   = !ent_rdata.acked && (age >= tmo_q);
	assign exhausted = (ent_rdata.retry >= retries_q);
	assign idx_seq   = 8'(idx_q) + 8'd1;
	assign next_seq  = 8'(next_q) + 8'd1;

	always_comb begin
		msg_we    = 1'b0;
		msg_waddr = len_eff[AW-1:0];
		msg_raddr = next_q[AW-1:0];
		ent_we    = 1'b0;
		ent_waddr = idx_q[AW-1:0];
		ent_wdata = '0;
		ent_raddr = base_q[AW-1:0];
		push      = '0;
		beat      = '0;
		unique case (state_q)
			ST_IDLE: begin
				msg_we    = in_acc && (s_tuser == CMD_LOAD) && load_ok && (len_eff < MAX_CNT);
				ent_raddr = ack_idx[AW-1:0];
			end
			ST_RF_CHK: msg_raddr = next_q[AW-1:0];
			ST_RF_EMIT: begin
				// first send: entry state starts fresh here
				push.prod       = 1'b1;
				beat.kind       = EV_NEW;
				beat.seq        = next_seq;
				beat.flags      = DATA_FLAG;
				beat.len        = 1'b1;
				beat.data       = msg_rdata;
				beat.sum        = pkt_sum(next_seq, 8'd0, DATA_FLAG, 8'd1, msg_rdata);
				ent_we          = 1'b1;
				ent_waddr       = next_q[AW-1:0];
				ent_wdata.stamp = now_q;
			end
			ST_ACK_WR: begin
				ent_we          = 1'b1;
				ent_wdata       = ent_rdata;
				ent_wdata.acked = 1'b1;
			end
			ST_SCAN_RD: ent_raddr = base_q[AW-1:0];
			ST_SCAN_END: begin
				if (base_q >= len_q && out_free) begin
					push.prod = 1'b1;
					beat.kind = EV_DONE;
				end
			end
			ST_TO_RD: begin
				ent_raddr = idx_q[AW-1:0];
				msg_raddr = idx_q[AW-1:0];
			end
			ST_TO_CHK: begin
				if (expired) begin
					push.prod = 1'b1;
					if (exhausted) begin
						beat.kind = EV_FAIL;
						beat.seq  = idx_seq;
					end else begin
						beat.kind       = EV_RETX;
						beat.seq        = idx_seq;
						beat.flags      = DATA_FLAG;
						beat.len        = 1'b1;
						beat.data       = msg_rdata;
						beat.sum        = pkt_sum(idx_seq, 8'd0, DATA_FLAG, 8'd1, msg_rdata);
						ent_we          = 1'b1;
						ent_wdata.retry = ent_rdata.retry + 4'd1;
						ent_wdata.stamp = now_q;
					end
				end
			end
			ST_FIN: push.fin = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LOADING;
			len_q   <= '0;
			base_q  <= '0;
			next_q  <= '0;
			idx_q   <= '0;
			now_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						now_q <= in_now;
						case (s_tuser)
							CMD_LOAD: begin
								if (load_ok) begin
									len_q   <= (len_eff < MAX_CNT) ? len_eff + 1'b1 : len_eff;
									phase_q <= PH_LOADING;
									if (s_tlast) begin
										base_q  <= '0;
										next_q  <= '0;
										phase_q <= PH_SENDING;
										state_q <= ST_RF_CHK;
									end
								end
							end
							CMD_ACK: begin
								if (ack_ok) begin
									idx_q   <= ack_idx[CW-1:0];
									state_q <= ST_ACK_WR;
								end
							end
							CMD_TIMEOUT: begin
								if (phase_q == PH_SENDING) begin
									idx_q   <= base_q;
									state_q <= ST_TO_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RF_CHK: begin
					if (!win_room) state_q <= ST_FIN;
					else if (out_free) state_q <= ST_RF_EMIT;
				end
				ST_RF_EMIT: begin
					next_q  <= next_q + 1'b1;
					state_q <= ST_RF_CHK;
				end
				ST_ACK_WR: state_q <= ST_SCAN_RD;
				ST_SCAN_RD: state_q <= (base_q < next_q) ? ST_SCAN_CHK : ST_SCAN_END;
				ST_SCAN_CHK: begin
					if (ent_rdata.acked) begin
						base_q  <= base_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					if (base_q < len_q) begin
						state_q <= ST_RF_CHK;
					end else if (out_free) begin
						phase_q <= PH_DONE;
						state_q <= ST_FIN;
					end
				end
				ST_TO_RD: begin
					if (idx_q >= next_q) state_q <= ST_FIN;
					else if (out_free) state_q <= ST_TO_CHK;
				end
				ST_TO_CHK: begin
					if (expired && exhausted) begin
						phase_q <= PH_FAILED;
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_TO_RD;
					end
				end
				ST_FIN: begin
					if (out_free || !pend_v) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a new result that displaces a pending one must find the output register free
	`SRS_ASSERT_NOW(a_prod_room, push.prod && pend_v, out_free)
	// a new item never starts while a result of the last one is still pending
	`SRS_ASSERT_NOW(a_idle_flushed, s_tready, !pend_v)
	// window pointers stay ordered and never span more than the widest window
	`SRS_ASSERT_NOW(a_window_order, phase_q == PH_SENDING,
		(base_q <= next_q) && (next_q <= len_q) && (SW'(next_q) <= SW'(base_q) + SW'(WIN_MAX)))
	// a timeout outside a transfer is dropped at once
	`SRS_ASSERT_NEXT(a_timeout_drop,
		in_acc && (s_tuser == CMD_TIMEOUT) && (phase_q != PH_SENDING), s_tready)
endmodule
`default_nettype wire

/* bench/tb_selective_repeat_sender_top.sv */
// ---------------------------------------------------------------------------
// tb_selective_repeat_sender_top
// self-checking bench for the selective repeat sender: a queue-fed driver
// pushes load, ack and timeout beats, a built-in sender model predicts every
// packet, done and fail beat, and a monitor compares them field by field
// ---------------------------------------------------------------------------
`default_nettype none
module tb_selective_repeat_sender_top;
	import srs_pkg::*;

	localparam int STORE_DEPTH = 128;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [7:0]  rx_seq;
		logic [7:0]  rx_ack;
		logic [7:0]  rx_flags;
		logic [7:0]  rx_len;
		logic [7:0]  rx_data;
		logic [15:0] rx_sum;
		logic [15:0] now_ms;
	} beat_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  seq;
		logic [7:0]  flags;
		logic        len;
		logic [7:0]  data;
		logic [15:0] sum;
		logic        last;
	} pkt_out_t;

	typedef enum logic [1:0] {
		PH_LOADING = 2'd0,
		PH_SENDING = 2'd1,
		PH_DONE    = 2'd2,
		PH_FAILED  = 2'd3
	} phase_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;  // data_byte, rx_seq, rx_ack_num, rx_flags, rx_len, rx_data,
	                       // rx_checksum, now_ms
	logic [1:0]  s_tuser;  // command
	logic        s_tlast;  // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // tx_seq, tx_flags, tx_len, tx_data, tx_checksum, pad
	logic [1:0]  m_tuser;  // event_kind
	logic        m_tlast;  // last_result
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	selective_repeat_sender_top dut (.*);

	// pending input beats and predicted output packets
	beat_in_t pending_beats[$];
	pkt_out_t predicted_pkts[$];

	// sender model state
	logic [7:0]  m_store[STORE_DEPTH];
	logic        m_acked[STORE_DEPTH];
	logic [3:0]  m_retry[STORE_DEPTH];
	logic [15:0] m_stamp[STORE_DEPTH];
	int unsigned m_len, m_base, m_next;
	phase_t      m_phase;
	logic [4:0]  m_window;
	logic [15:0] m_timeout;
	logic [3:0]  m_retries;

	int errors = 0;
	int stall_cycles = 0;
	int beats_in = 0;
	int pkts_out = 0;
	int n_retx = 0, n_done = 0, n_fail = 0;
	bit quiet = 0;
	bit taken = 0;

	// generator side
	logic [15:0] gen_now = 16'd0;
	logic [15:0] gen_timeout = 16'd350;
	int gen_count = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [15:0] fold_sum(input logic [7:0] s, a, f, l, d);
		logic [31:0] t;
		t = 32'(s) + 32'(a) + 32'(f) + 32'(l) + 32'(d);
		while (t[31:16] != 0)
			t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
		return ~t[15:0];
	endfunction

	function automatic int unsigned clamp_window(input logic [4:0] w);
		if (w == 0) return 1;
		if (w > 16) return 16;
		return w;
	endfunction

	function automatic pkt_out_t data_pkt(input logic [1:0] kind, input int unsigned idx);
		pkt_out_t p;
		p.kind = kind;
		p.seq = 8'(idx + 1);
		p.flags = DATA_FLAG;
		p.len = 1'b1;
		p.data = m_store[idx];
		p.sum = fold_sum(p.seq, 8'd0, DATA_FLAG, 8'd1, p.data);
		p.last = 1'b0;
		return p;
	endfunction

	function automatic pkt_out_t ctrl_pkt(input logic [1:0] kind, input logic [7:0] seq);
		pkt_out_t p;
		p = '{kind: kind, seq: seq, flags: 8'd0, len: 1'b0, data: 8'd0, sum: 16'd0,
			last: 1'b0};
		return p;
	endfunction

	task automatic refill_window(input logic [15:0] now, inout pkt_out_t outs[$]);
		int unsigned w;
		w = clamp_window(m_window);
		while (m_next < m_len && m_next < m_base + w) begin
			m_stamp[m_next] = now;
			outs.push_back(data_pkt(EV_NEW, m_next));
			m_next++;
		end
	endtask

	// advance the sender model by one accepted beat
	task automatic sender_model_step(input beat_in_t b);
		pkt_out_t outs[$];
		logic [15:0] age;
		int unsigned ack;
		if (b.cmd == CMD_LOAD) begin
			if (m_phase == PH_DONE || m_phase == PH_FAILED) begin
				m_len = 0;
				m_phase = PH_LOADING;
			end
			if (m_phase == PH_LOADING) begin
				if (m_len < STORE_DEPTH) begin
					m_store[m_len] = b.data_byte;
					m_len++;
				end
				if (b.last_byte) begin
					for (int i = 0; i < STORE_DEPTH; i++) begin
						m_acked[i] = 0;
						m_retry[i] = 0;
					end
					m_base = 0;
					m_next = 0;
					m_phase = PH_SENDING;
					refill_window(b.now_ms, outs);
				end
			end
		end else if (b.cmd == CMD_ACK) begin
			ack = b.rx_ack;
			if (m_phase == PH_SENDING && b.rx_flags[ACK_BIT] &&
					b.rx_sum == fold_sum(b.rx_seq, b.rx_ack, b.rx_flags, b.rx_len, b.rx_data) &&
					ack >= 1 && ack <= m_len && ack - 1 >= m_base && ack - 1 < m_next) begin
				m_acked[ack - 1] = 1;
				while (m_base < m_len && m_acked[m_base])
					m_base++;
				if (m_base >= m_len) begin
					m_phase = PH_DONE;
					outs.push_back(ctrl_pkt(EV_DONE, 8'd0));
				end else begin
					refill_window(b.now_ms, outs);
				end
			end
		end else if (b.cmd == CMD_TIMEOUT && m_phase == PH_SENDING) begin
			for (int unsigned i = m_base; i < m_next && i < STORE_DEPTH; i++) begin
				if (m_acked[i]) continue;
				age = b.now_ms - m_stamp[i];
				if (age < m_timeout) continue;
				if (m_retry[i] >= m_retries) begin
					m_phase = PH_FAILED;
					outs.push_back(ctrl_pkt(EV_FAIL, 8'(i + 1)));
					break;
				end
				m_retry[i] = m_retry[i] + 4'd1;
				m_stamp[i] = b.now_ms;
				outs.push_back(data_pkt(EV_RETX, i));
			end
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[k])
			predicted_pkts.push_back(outs[k]);
	endtask

	// accept side: config mirror, model update, result compare, stall watchdog
	always @(posedge clk) begin
		pkt_out_t got, want;
		bit moved;
		moved = 0;
		if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW:  m_window <= cfg_data[4:0];
				CFG_TIMEOUT: m_timeout <= cfg_data;
				CFG_RETRIES: m_retries <= cfg_data[3:0];
				default: ;
			endcase
		end
		if (arst_n && s_tvalid && s_tready) begin
			sender_model_step(pending_beats[0]);
			pending_beats.pop_front();
			taken = 1;
			beats_in++;
			moved = 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			moved = 1;
			got.kind = m_tuser;
			got.seq = m_tdata[7:0];
			got.flags = m_tdata[15:8];
			got.len = m_tdata[16];
			got.data = m_tdata[24:17];
			got.sum = m_tdata[40:25];
			got.last = m_tlast;
			pkts_out++;
			if (predicted_pkts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat kind=%0d seq=%0d", got.kind, got.seq);
			end else begin
				want = predicted_pkts.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch exp: kind=%0d seq=%h flags=%h len=%0d data=%h",
							want.kind, want.seq, want.flags, want.len, want.data);
						$display("  exp sum=%h last=%0d", want.sum, want.last);
						$display("  got: kind=%0d seq=%h flags=%h len=%0d data=%h",
							got.kind, got.seq, got.flags, got.len, got.data);
						$display("  got sum=%h last=%0d", got.sum, got.last);
					end
				end
				case (want.kind)
					EV_RETX: n_retx++;
					EV_DONE: n_done++;
					EV_FAIL: n_fail++;
					default: ;
				endcase
			end
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("tb_selective_repeat_sender_top: errors");
			$finish;
		end
	end

	// driver: new beats at the falling edge from the pending queue, plus random m_tready
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || taken) begin
				taken = 0;
				// pending_beats[0] is the beat on the bus; the head moves only on accept
				if (pending_beats.size() > 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {pending_beats[0].now_ms, pending_beats[0].rx_sum,
						pending_beats[0].rx_data, pending_beats[0].rx_len,
						pending_beats[0].rx_flags, pending_beats[0].rx_ack,
						pending_beats[0].rx_seq, pending_beats[0].data_byte};
					s_tuser <= pending_beats[0].cmd;
					s_tlast <= pending_beats[0].last_byte;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= quiet || $urandom_range(0, 99) >= 8;
		end
	end

	task automatic add_beat(input logic [1:0] cmd, input logic [7:0] db, input logic lb,
		input logic [7:0] sq, ak, fl, ln, dt, input logic [15:0] ck, input logic [15:0] now);
		beat_in_t b;
		b = '{cmd, db, lb, sq, ak, fl, ln, dt, ck, now};
		pending_beats.push_back(b);
		gen_count++;
	endtask

	task automatic add_load(input logic [7:0] db, input logic lb);
		add_beat(CMD_LOAD, db, lb, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 16'($urandom), gen_now);
	endtask

	task automatic add_ack(input logic [7:0] ak, input bit good_sum, input bit ack_flag);
		logic [7:0] sq, fl, ln, dt;
		logic [15:0] ck;
		sq = 8'($urandom);
		fl = 8'($urandom);
		fl[ACK_BIT] = ack_flag;
		ln = 8'($urandom);
		dt = 8'($urandom);
		ck = fold_sum(sq, ak, fl, ln, dt);
		if (!good_sum) ck = ck ^ 16'(1 << $urandom_range(0, 15));
		add_beat(CMD_ACK, 8'($urandom), 1'($urandom), sq, ak, fl, ln, dt, ck, gen_now);
	endtask

	task automatic add_timeout();
		add_beat(CMD_TIMEOUT, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), gen_now);
	endtask

	// one message: its bytes, then a mix of acks, timeouts and noise
	task automatic add_message(input int n, input int events);
		int r;
		for (int k = 0; k < n; k++)
			add_load(8'($urandom), k == n - 1);
		for (int e = 0; e < events; e++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				gen_now += 16'($urandom_range(0, 40));
				add_ack(8'($urandom_range(1, n)), 1, 1);
			end else if (r < 85) begin
				gen_now += ($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($urandom_range(0, 2 * int'(gen_timeout)));
				add_timeout();
			end else begin
				case ($urandom_range(0, 4))
					0: add_ack(8'($urandom_range(1, n)), 0, 1);
					1: add_ack(8'($urandom_range(1, n)), 1, 0);
					2: add_ack(8'($urandom), 1, 1);
					3: add_beat(2'd3, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), gen_now);
					default: add_load(8'($urandom), 1'($urandom));
				endcase
			end
		end
	endtask

	task automatic drain();
		wait (pending_beats.size() == 0 && !s_tvalid && predicted_pkts.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TIMEOUT) gen_timeout = (val == 0) ? 16'd1 : val;
	endtask

	task automatic set_all(input logic [4:0] w, input logic [15:0] t, input logic [3:0] r);
		write_reg(CFG_WINDOW, 16'(w));
		write_reg(CFG_TIMEOUT, t);
		write_reg(CFG_RETRIES, 16'(r));
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_len = 0;
		m_base = 0;
		m_next = 0;
		m_phase = PH_LOADING;
		m_window = 5'd4;
		m_timeout = 16'd350;
		m_retries = 4'd15;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			m_acked[i] = 0;
			m_retry[i] = 0;
			m_store[i] = 0;
			m_stamp[i] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, extreme bytes, several rejection paths
		gen_now = 16'hFFFF;
		add_load(8'h00, 0);
		add_load(8'hFF, 1);
		add_ack(8'd2, 1, 1);          // out of order ack
		add_ack(8'd1, 0, 1);          // bad checksum
		add_ack(8'd1, 1, 0);          // ack flag clear
		add_ack(8'd0, 1, 1);          // ack number zero
		add_ack(8'd200, 1, 1);        // beyond the message
		add_beat(2'd3, 8'hFF, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, gen_now);
		add_load(8'h5A, 1);           // load while sending is dropped
		gen_now = 16'd100;            // age wraps to 101, below timeout
		add_timeout();
		gen_now = 16'd400;
		add_timeout();                // resend of the first entry
		add_ack(8'd1, 1, 1);          // finishes the transfer
		add_ack(8'd1, 1, 1);          // after done, ignored
		add_timeout();                // after done, ignored
		add_load(8'hA5, 1);           // new message after done
		add_ack(8'd1, 1, 1);
		drain();

		// no retries, timeout of 1: first timeout fails
		set_all(5'd1, 16'd1, 4'd0);
		add_load(8'h3C, 0);
		add_load(8'hC3, 1);
		gen_now += 16'd5;
		add_timeout();
		add_timeout();                // after failure, ignored
		drain();

		// full store: bytes past the end are dropped, window at its widest
		set_all(5'd16, 16'd65535, 4'd15);
		quiet = 1;
		add_message(130, 40);
		drain();
		quiet = 0;

		// random phases through several settings
		target = 420;
		for (int ph = 0; gen_count < target; ph++) begin
			case (ph % 6)
				0: set_all(5'd4, 16'd350, 4'd15);
				1: set_all(5'd0, 16'd100, 4'd2);
				2: set_all(5'd31, 16'd7, 4'd1);
				3: set_all(5'd16, 16'd65535, 4'd0);
				4: set_all(5'd1, 16'd1, 4'd3);
				default: set_all(5'($urandom_range(0, 31)), 16'($urandom),
					4'($urandom));
			endcase
			for (int m = 0; m < 4; m++)
				add_message($urandom_range(1, 12), $urandom_range(5, 25));
			drain();
		end

		$display("covered %0d input beats, %0d result beats", beats_in, pkts_out);
		$display("including %0d resends, %0d completed and %0d failed transfers",
			n_retx, n_done, n_fail);
		if (errors == 0) begin
			$display("tb_selective_repeat_sender_top: clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_selective_repeat_sender_top: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
